// ----- rtl/lhp_pkg.sv -----
// Package with types, constants and the bound lookup for the latency histogram.
`timescale 1ns / 1ps

package lhp_pkg;

    localparam int NUM_BUCKETS_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TOTAL_W         = 37;
    localparam int FRAC_W          = 17;
    localparam int FRAC_SHIFT      = 16;
    localparam int LAT_W           = 32;

    localparam logic [FRAC_W-1:0]  FRAC_ONE  = 17'h10000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [LAT_W-1:0]  latency_us;
        logic [FRAC_W-1:0] fraction;
    } t_in_beat;

    typedef struct packed {
        logic [32:0] bound_us;
        logic [22:0] bound_ms;
        logic [4:0]  bucket_index;
        logic        empty_res;
    } t_out_beat;

    typedef struct packed {
        logic inc;
        logic clr;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TARGET,
        S_WALK,
        S_DONE
    } t_state_e;

    // Milliseconds for a bound of 2^(idx+1) microseconds, saturated to 23 bits.
    function automatic logic [22:0] lhp_ms_of(input logic [6:0] idx);
        logic [22:0] ms;
        if (idx < 7'd9) begin
            ms = '0;
        end else begin
            case (idx)
                7'd9:    ms = 23'd1;
                7'd10:   ms = 23'd2;
                7'd11:   ms = 23'd4;
                7'd12:   ms = 23'd8;
                7'd13:   ms = 23'd16;
                7'd14:   ms = 23'd32;
                7'd15:   ms = 23'd65;
                7'd16:   ms = 23'd131;
                7'd17:   ms = 23'd262;
                7'd18:   ms = 23'd524;
                7'd19:   ms = 23'd1048;
                7'd20:   ms = 23'd2097;
                7'd21:   ms = 23'd4194;
                7'd22:   ms = 23'd8388;
                7'd23:   ms = 23'd16777;
                7'd24:   ms = 23'd33554;
                7'd25:   ms = 23'd67108;
                7'd26:   ms = 23'd134217;
                7'd27:   ms = 23'd268435;
                7'd28:   ms = 23'd536870;
                7'd29:   ms = 23'd1073741;
                7'd30:   ms = 23'd2147483;
                7'd31:   ms = 23'd4294967;
                default: ms = 23'h7FFFFF;
            endcase
        end
        return ms;
    endfunction

endpackage

// ----- rtl/log2_latency_histogram_percentile_top.sv -----
// Latency histogram top: request decode, sample total, walk sequencer and result register.
`timescale 1ns / 1ps

// Power-of-two latency histogram held in a row of counter cells. A record beat is taken
// every cycle while the block is idle and bumps one bucket in place. A clear beat zeroes
// every cell and the sample total. A query beat forms the target from the sample total,
// then passes a running sum down the cell row one cell per cycle until the target or the
// last cell is reached (an empty histogram skips the walk and gives an empty result); no
// new beat is taken until the query is done, and the length of the cell row bounds that
// time. A query also holds in its done state while an earlier result waits unaccepted in
// the output register, where a result waits while record and clear beats are still taken.
module log2_latency_histogram_percentile_top
    import lhp_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam int CUM_W = ((COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W) + 1;
    localparam int PROD_W = TOTAL_W + FRAC_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

    t_state_e           r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_res_idx, n_res_idx;
    logic               r_res_empty, n_res_empty;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [TOTAL_W-1:0] r_target, n_target;
    logic [TOTAL_W-1:0] r_total, n_total;
    t_out_beat          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic                   w_inc_en;
    logic                   w_clr_en;
    logic                   w_start;
    logic [5:0]             w_msb;
    logic [IDX_W-1:0]       w_bkt;
    logic [PROD_W-1:0]      w_prod;
    logic [6:0]             w_idx7;
    logic [NUM_BUCKETS-1:0] w_full;
    logic [NUM_BUCKETS-1:0] w_hit;
    logic [NUM_BUCKETS-1:0] w_tok;
    logic [CUM_W-1:0]       w_cum [NUM_BUCKETS];
    logic                   w_tok_end;

    always_comb begin
        w_msb = '0;
        for (int j = 1; j < LAT_W; j++) begin
            if (i_in_data.latency_us[j]) begin
                w_msb = 6'(j);
            end
        end
    end

    assign w_bkt = (32'(w_msb) > 32'(NUM_BUCKETS - 1)) ? LAST_IDX : IDX_W'(w_msb);

    assign w_prod = PROD_W'(r_total) * PROD_W'(r_frac);
    assign w_idx7 = 7'(r_res_idx);

    assign w_tok[0] = w_start;
    assign w_cum[0] = '0;

    for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.inc = w_inc_en && (w_bkt == IDX_W'(g));
        assign w_ctl.clr = w_clr_en;

        if (g < NUM_BUCKETS - 1) begin : g_mid
            lhp_cell #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .CUM_W       (CUM_W)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_tok    (w_tok[g]),
                .i_cum    (w_cum[g]),
                .i_target (r_target),
                .o_tok    (w_tok[g+1]),
                .o_cum    (w_cum[g+1]),
                .o_hit    (w_hit[g]),
                .o_full   (w_full[g])
            );
        end else begin : g_last
            lhp_cell #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .CUM_W       (CUM_W)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_tok    (w_tok[g]),
                .i_cum    (w_cum[g]),
                .i_target (r_target),
                .o_tok    (w_tok_end),
                .o_cum    (),
                .o_hit    (w_hit[g]),
                .o_full   (w_full[g])
            );
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_res_idx   = r_res_idx;
        n_res_empty = r_res_empty;
        n_frac      = r_frac;
        n_target    = r_target;
        n_total     = r_total;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        w_inc_en    = 1'b0;
        w_clr_en    = 1'b0;
        w_start     = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_data.req_type)
                        REQ_RECORD: begin
                            w_inc_en = 1'b1;
                            if (!w_full[w_bkt] && (r_total != TOTAL_MAX)) begin
                                n_total = r_total + TOTAL_W'(1);
                            end
                        end
                        REQ_QUERY: begin
                            if (r_total == '0) begin
                                n_res_empty = 1'b1;
                                n_state     = S_DONE;
                            end else begin
                                n_res_empty = 1'b0;
                                n_frac      = (i_in_data.fraction > FRAC_ONE) ?
                                              FRAC_ONE : i_in_data.fraction;
                                n_state     = S_TARGET;
                            end
                        end
                        REQ_CLEAR: begin
                            w_clr_en = 1'b1;
                            n_total  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TARGET: begin
                n_target = w_prod[TOTAL_W+FRAC_SHIFT-1:FRAC_SHIFT];
                n_idx    = '0;
                n_state  = S_WALK;
            end
            S_WALK: begin
                w_start = (r_idx == '0);
                if ((|w_hit) || (r_idx == LAST_IDX)) begin
                    n_res_idx = r_idx;
                    n_state   = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_res_empty) begin
                        n_out           = '0;
                        n_out.empty_res = 1'b1;
                    end else begin
                        n_out.bound_us     = (w_idx7 >= 7'd32) ? {33{1'b1}} :
                                             (33'(1) << (w_idx7 + 7'd1));
                        n_out.bound_ms     = lhp_ms_of(w_idx7);
                        n_out.bucket_index = (w_idx7 > 7'd31) ? 5'd31 : w_idx7[4:0];
                        n_out.empty_res    = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_idx   <= n_res_idx;
        r_res_empty <= n_res_empty;
        r_frac      <= n_frac;
        r_target    <= n_target;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_tok_stays_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tok_end)
        else $error("walk ran past the last cell");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell hit the target");

    a_hit_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |-> (w_hit == '0))
        else $error("cell hit outside a walk");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !r_out_valid) |-> (r_state == S_DONE))
        else $error("result loaded outside the done state");

endmodule

// ----- rtl/lhp_cell.sv -----
// One histogram cell: a saturating bucket counter and one stage of the percentile walk.
`timescale 1ns / 1ps

module lhp_cell
    import lhp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int CUM_W       = TOTAL_W + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic               i_tok,
    input  logic [CUM_W-1:0]   i_cum,
    input  logic [TOTAL_W-1:0] i_target,
    output logic               o_tok,
    output logic [CUM_W-1:0]   o_cum,
    output logic               o_hit,
    output logic               o_full
);

    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_tok, n_tok;
    logic [CUM_W-1:0]       r_cum, n_cum;
    logic [CUM_W:0]         w_sum_x;
    logic [CUM_W-1:0]       w_sum;

    assign o_full  = &r_cnt;
    assign w_sum_x = {1'b0, i_cum} + (CUM_W + 1)'(r_cnt);
    assign w_sum   = w_sum_x[CUM_W] ? {CUM_W{1'b1}} : w_sum_x[CUM_W-1:0];
    assign o_hit   = i_tok && (w_sum >= CUM_W'(i_target));

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.clr) begin
            n_cnt = '0;
        end else if (i_ctl.inc && !o_full) begin
            n_cnt = r_cnt + COUNT_WIDTH'(1);
        end
        n_tok = i_tok && !o_hit;
        n_cum = w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tok <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cum <= n_cum;
    end

    assign o_tok = r_tok;
    assign o_cum = r_cum;

endmodule

// ----- tb/log2_latency_histogram_percentile_top_tb.sv -----
// Self-checking testbench for the log2 latency histogram with percentile queries.
`timescale 1ns / 1ps

module log2_latency_histogram_percentile_top_tb;
    import lhp_pkg::*;

    localparam int NB        = NUM_BUCKETS_DEF;
    localparam int CNT_W     = COUNT_WIDTH_DEF;
    localparam int RUN_LIMIT = 400000;
    localparam int N_RANDOM  = 850;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    class hist_scoreboard;
        logic [63:0] bucket_cnt [NB];
        logic [36:0] sample_sum;
        t_out_beat   pending_q [$];
        int          errors;

        function new();
            clear_hist();
            errors = 0;
        endfunction

        function void clear_hist();
            foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
            sample_sum = '0;
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_input(t_in_beat b);
            int          bkt;
            int          idx;
            bit          found;
            logic [63:0] cnt_max;
            logic [63:0] target;
            logic [63:0] cum;
            logic [63:0] bound;
            logic [16:0] frac;
            t_out_beat   res;
            cnt_max = (CNT_W >= 64) ? {64{1'b1}} : ((64'd1 << CNT_W) - 1);
            case (b.req_type)
                REQ_RECORD: begin
                    bkt = 0;
                    for (int i = 1; i < 32; i++) begin
                        if (b.latency_us[i]) bkt = i;
                    end
                    if (bkt > NB - 1) bkt = NB - 1;
                    if (bucket_cnt[bkt] < cnt_max) begin
                        bucket_cnt[bkt]++;
                        if (sample_sum != TOTAL_MAX) sample_sum++;
                    end
                end
                REQ_CLEAR: begin
                    clear_hist();
                end
                REQ_QUERY: begin
                    if (sample_sum == '0) begin
                        res = '0;
                        res.empty_res = 1'b1;
                    end else begin
                        frac   = (b.fraction > FRAC_ONE) ? FRAC_ONE : b.fraction;
                        target = (64'(sample_sum) * 64'(frac)) >> FRAC_SHIFT;
                        cum    = '0;
                        idx    = NB - 1;
                        found  = 1'b0;
                        for (int i = 0; i < NB; i++) begin
                            cum = cum + bucket_cnt[i];
                            if (!found && cum >= target) begin
                                idx   = i;
                                found = 1'b1;
                            end
                        end
                        bound            = 64'd1 << (idx + 1);
                        res.bound_us     = 33'(bound);
                        res.bound_ms     = 23'(bound / 64'd1000);
                        res.bucket_index = 5'(idx);
                        res.empty_res    = 1'b0;
                    end
                    pending_q.push_back(res);
                end
                default: begin
                end
            endcase
        endfunction

        task check_result(t_out_beat got);
            t_out_beat want;
            if (pending_q.size() == 0) begin
                report("result beat with no query pending");
                return;
            end
            want = pending_q.pop_front();
            if (got.bound_us !== want.bound_us)
                report($sformatf("bound_us got %0d want %0d", got.bound_us, want.bound_us));
            if (got.bound_ms !== want.bound_ms)
                report($sformatf("bound_ms got %0d want %0d", got.bound_ms, want.bound_ms));
            if (got.bucket_index !== want.bucket_index)
                report($sformatf("bucket_index got %0d want %0d",
                                 got.bucket_index, want.bucket_index));
            if (got.empty_res !== want.empty_res)
                report($sformatf("empty_res got %0b want %0b", got.empty_res, want.empty_res));
        endtask

        task flush();
            while (pending_q.size() != 0) begin
                void'(pending_q.pop_front());
                report("query result never arrived");
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    hist_scoreboard sb;
    int             burst_left;
    int             hold_left;
    bit             hold_off_req;

    log2_latency_histogram_percentile_top #(
        .NUM_BUCKETS(NB),
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic offer(input logic [1:0] req, input logic [31:0] lat,
                         input logic [16:0] frac);
        t_in_beat b;
        int       gap;
        b.req_type   = req;
        b.latency_us = lat;
        b.fraction   = frac;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(b);
    endtask

    initial begin
        int          cyc;
        int          mode;
        i_out_ready <= 1'b0;
        cyc  = 0;
        mode = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
            cyc++;
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= (cyc % 4 == 0);
                    default: i_out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        int cyc_count;
        cyc_count = 0;
        while (cyc_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cyc_count++;
        end
        $display("log2_latency_histogram_percentile_top_tb failed");
        $finish;
    end

    initial begin
        int          pick;
        int          k;
        logic [31:0] lat;
        logic [16:0] frac;
        sb           = new();
        burst_left   = 0;
        hold_off_req = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(REQ_QUERY,  32'd0,          FRAC_ONE);
        offer(REQ_UNUSED, 32'd5,          17'd100);
        offer(REQ_RECORD, 32'd0,          17'd0);
        offer(REQ_RECORD, 32'd1,          17'h1FFFF);
        offer(REQ_RECORD, 32'd2,          17'd0);
        offer(REQ_RECORD, 32'd3,          17'd0);
        offer(REQ_RECORD, 32'hFFFF_FFFF,  17'd0);
        offer(REQ_RECORD, 32'h8000_0000,  17'd0);
        offer(REQ_RECORD, 32'h7FFF_FFFF,  17'd0);
        offer(REQ_QUERY,  32'd0,          17'd0);
        offer(REQ_QUERY,  32'd0,          FRAC_ONE);
        offer(REQ_QUERY,  32'hFFFF_FFFF,  17'h1FFFF);
        offer(REQ_QUERY,  32'd0,          17'd65537);
        offer(REQ_QUERY,  32'd0,          17'd32768);
        offer(REQ_RECORD, 32'd1000,       17'd0);
        offer(REQ_QUERY,  32'd0,          17'd1);
        offer(REQ_CLEAR,  32'hFFFF_FFFF,  17'h1FFFF);
        offer(REQ_QUERY,  32'd0,          17'd32768);
        offer(REQ_RECORD, 32'd1024,       17'd0);
        offer(REQ_QUERY,  32'd0,          FRAC_ONE);
        offer(REQ_UNUSED, 32'hFFFF_FFFF,  17'h1FFFF);
        offer(REQ_QUERY,  32'd0,          17'd0);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 150) hold_off_req = 1'b1;
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, 31);
            case ($urandom_range(0, 3))
                0:       lat = $urandom;
                1:       lat = 32'd1 << k;
                2:       lat = (32'd1 << k) - 32'd1;
                default: lat = $urandom >> (31 - k);
            endcase
            case ($urandom_range(0, 7))
                0:       frac = '0;
                1:       frac = FRAC_ONE;
                2:       frac = 17'($urandom_range(65537, 131071));
                default: frac = 17'($urandom_range(0, 65536));
            endcase
            if (n >= 300 && n < 600) begin
                // pile samples into one bucket
                if (pick < 92) offer(REQ_RECORD, 32'd32 + 32'($urandom_range(0, 31)), frac);
                else           offer(REQ_QUERY, lat, frac);
            end else if (pick < 70) begin
                offer(REQ_RECORD, lat, frac);
            end else if (pick < 90) begin
                offer(REQ_QUERY, lat, frac);
            end else if (pick < 93) begin
                offer(REQ_CLEAR, lat, frac);
            end else if (pick < 96) begin
                offer(REQ_UNUSED, lat, frac);
            end else begin
                offer(REQ_RECORD, lat, frac);
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        sb.flush();
        if (sb.errors == 0) begin
            $display("log2_latency_histogram_percentile_top_tb passed");
        end else begin
            $display("log2_latency_histogram_percentile_top_tb failed");
        end
        $finish;
    end

endmodule
